// ===== rtl/tdpt_pkg.sv =====
// Shared types and constants for the trial-division prime tester.
// No dependencies; used by tdpt_divider and trial_division_prime_test.
`default_nettype none

package tdpt_pkg;

    // Width of the candidate and echo ports.
    localparam int CAND_BITS = 32;

    // Default number of candidate bits taken into the test.
    localparam int DEFAULT_VALUE_BITS = 32;

    // Status of the serial divider as seen by the controller.
    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

`default_nettype wire

// ===== rtl/tdpt_divider.sv =====
// Bit-serial restoring divider: one quotient bit per cycle.
// Depends on tdpt_pkg for the status struct.
`default_nettype none

module tdpt_divider #(
    parameter int NB = 32
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_start,
    input  wire logic [NB-1:0]        i_dividend,
    input  wire logic [NB-1:0]        i_divisor,
    output tdpt_pkg::t_div_stat       o_stat,
    output logic      [NB-1:0]        o_quotient,
    output logic      [NB-1:0]        o_remainder
);

    localparam int CW = $clog2(NB + 1);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [NB-1:0] r_quo;
    logic [NB-1:0] r_rem;
    logic [NB-1:0] r_dvs;

    logic [NB:0]   trial;
    logic [NB:0]   diff;
    logic          fits;

    // Bring down the next dividend bit and try the subtract.
    assign trial = {r_rem, r_quo[NB-1]};
    assign diff  = trial - {1'b0, r_dvs};
    assign fits  = !diff[NB];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (r_busy) begin
                r_rem <= fits ? diff[NB-1:0] : trial[NB-1:0];
                r_quo <= {r_quo[NB-2:0], fits};
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end else if (i_start) begin
                r_quo  <= i_dividend;
                r_rem  <= '0;
                r_dvs  <= i_divisor;
                r_cnt  <= CW'(NB);
                r_busy <= 1'b1;
            end
        end
    end

    assign o_stat.busy  = r_busy;
    assign o_stat.done  = r_done;
    assign o_quotient   = r_quo;
    assign o_remainder  = r_rem;

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_busy)
        else $error("divider done while busy");

    a_cnt_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> r_cnt != '0)
        else $error("divider busy with zero count");

    a_rem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_done && r_dvs != '0) |-> r_rem < r_dvs)
        else $error("remainder not below divisor");

    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> !r_done)
        else $error("done held longer than one cycle");

endmodule

`default_nettype wire

// ===== rtl/trial_division_prime_test.sv =====
// Top level of the trial-division prime tester: controller and result register.
// Depends on tdpt_pkg and tdpt_divider.
//
// Usage:
//   Drive i_candidate and pulse start while busy is low; the candidate is
//   taken at that edge. One result follows per candidate: o_result_valid is
//   high for exactly one cycle with o_tested_value (the candidate masked to
//   VALUE_BITS bits) and o_is_prime. The receiver cannot stall; a result not
//   taken in its strobe cycle is lost.
// Run behaviour:
//   Zero, one, two, three and even numbers are decided directly: the result
//   strobe follows in the cycle after start and busy stays low, so a new
//   candidate can follow at once. Odd candidates above three run trial
//   divisors 3, 5, 7, ... through one bit-serial divider, each in the steps
//   launch, load, one quotient bit per cycle, decide, until a divisor exceeds
//   the quotient or divides evenly. busy is high for the whole run.
// Reset: synchronous, active low; returns to idle and drops any run in progress.
`default_nettype none

module trial_division_prime_test #(
    parameter int VALUE_BITS = tdpt_pkg::DEFAULT_VALUE_BITS
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [tdpt_pkg::CAND_BITS-1:0] i_candidate,
    output logic                               o_result_valid,
    output logic      [tdpt_pkg::CAND_BITS-1:0] o_tested_value,
    output logic                               o_is_prime
);

    localparam int CB = tdpt_pkg::CAND_BITS;
    localparam int NB = (VALUE_BITS < CB) ? VALUE_BITS : CB;

    typedef enum logic [0:0] {
        S_IDLE,
        S_DIV
    } t_state;

    t_state               r_state;
    logic                 r_div_start;
    logic                 r_valid;
    logic [NB-1:0]        r_n;
    logic [NB-1:0]        r_d;
    logic [CB-1:0]        r_value;
    logic                 r_prime;

    logic [NB-1:0]        cand;
    tdpt_pkg::t_div_stat  div_stat;
    logic [NB-1:0]        div_quo;
    logic [NB-1:0]        div_rem;

    assign cand = i_candidate[NB-1:0];

    tdpt_divider #(
        .NB (NB)
    ) u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (r_div_start),
        .i_dividend  (r_n),
        .i_divisor   (r_d),
        .o_stat      (div_stat),
        .o_quotient  (div_quo),
        .o_remainder (div_rem)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_div_start <= 1'b0;
            r_valid     <= 1'b0;
        end else begin
            r_valid     <= 1'b0;
            r_div_start <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_n     <= cand;
                        r_value <= CB'(cand);
                        priority if (cand[NB-1:1] == '0) begin
                            r_prime <= 1'b0;
                            r_valid <= 1'b1;
                        end else if (cand[NB-1:2] == '0) begin
                            r_prime <= 1'b1;
                            r_valid <= 1'b1;
                        end else if (!cand[0]) begin
                            r_prime <= 1'b0;
                            r_valid <= 1'b1;
                        end else begin
                            r_d         <= NB'(3);
                            r_div_start <= 1'b1;
                            r_state     <= S_DIV;
                        end
                    end
                end
                S_DIV: begin
                    if (div_stat.done) begin
                        // Stop once the divisor passes n / d, or on an exact divide.
                        priority if (r_d > div_quo) begin
                            r_prime <= 1'b1;
                            r_valid <= 1'b1;
                            r_state <= S_IDLE;
                        end else if (div_rem == '0) begin
                            r_prime <= 1'b0;
                            r_valid <= 1'b1;
                            r_state <= S_IDLE;
                        end else begin
                            r_d         <= r_d + NB'(2);
                            r_div_start <= 1'b1;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign busy           = (r_state != S_IDLE);
    assign o_result_valid = r_valid;
    assign o_tested_value = r_value;
    assign o_is_prime     = r_prime;

    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> r_state == S_IDLE)
        else $error("result strobe while a run is in progress");

    a_launch_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_div_start |-> (r_state == S_DIV && !div_stat.busy))
        else $error("divider launch outside a run or while divider busy");

    a_done_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_stat.done |-> r_state == S_DIV)
        else $error("divider finished outside a run");

    a_prime_odd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_prime) |-> (r_value[0] || r_value == CB'(2)))
        else $error("even value above two reported prime");

endmodule

`default_nettype wire
